>>> sv/lf2c_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lf2c_pkg
// Shared types and constants for the local frame spherical to cartesian block.
// ----------------------------------------------------------------------------
package lf2c_pkg;

   localparam int ANGLE_W   = 16;
   localparam int DIST_W    = 16;
   localparam int COMP_W    = 16;
   localparam int ROW_W     = 3 * COMP_W;
   localparam int ORIGIN_W  = 24;
   localparam int ZW        = 34;
   localparam int XW        = 33;
   localparam int MAX_STAGES = 24;

   localparam logic signed [ZW-1:0] PI_Q30      = 34'sd3373259426;
   localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
   localparam logic signed [XW-1:0] GAIN_Q30    = 33'sd652032874;

   localparam logic signed [ZW-1:0] ATAN_Q30 [MAX_STAGES] = '{
      34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
      34'sd67021687,  34'sd33543516,  34'sd16775851,  34'sd8388437,
      34'sd4194283,   34'sd2097149,   34'sd1048576,   34'sd524288,
      34'sd262144,    34'sd131072,    34'sd65536,     34'sd32768,
      34'sd16384,     34'sd8192,      34'sd4096,      34'sd2048,
      34'sd1024,      34'sd512,       34'sd256,       34'sd128
   };

   typedef struct packed {
      logic [XW-1:0] sin_q30;
      logic [XW-1:0] cos_q30;
   } trig_type;

   typedef struct packed {
      logic [ORIGIN_W-1:0] origin_z;
      logic [ORIGIN_W-1:0] origin_y;
      logic [ORIGIN_W-1:0] origin_x;
      logic [ROW_W-1:0]    basis_row2;
      logic [ROW_W-1:0]    basis_row1;
      logic [ROW_W-1:0]    basis_row0;
      logic [DIST_W-1:0]   distance;
   } side_type;

endpackage
`default_nettype wire

>>> sv/lf2c_cordic.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lf2c_cordic
// Pipelined rotation-mode CORDIC giving sine and cosine of a Q3.13 angle.
// ----------------------------------------------------------------------------
module lf2c_cordic #(
   parameter int STAGES = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  en,
   input  wire logic signed [lf2c_pkg::ANGLE_W-1:0]   angle,
   output lf2c_pkg::trig_type                         trig
);
   import lf2c_pkg::*;

   logic signed [XW-1:0] x_ff [0:STAGES];
   logic signed [XW-1:0] y_ff [0:STAGES];
   logic signed [ZW-1:0] z_ff [0:STAGES];
   logic                 neg_ff [0:STAGES];
   logic signed [ZW-1:0] z0_in;
   logic                 neg0_in;
   logic signed [ZW-1:0] zw;
   trig_type             trig_ff;
   trig_type             trig_in;

   always_comb begin
      zw = {angle[ANGLE_W-1], angle, 17'b0};
      if (zw > HALF_PI_Q30) begin
         z0_in   = zw - PI_Q30;
         neg0_in = 1'b1;
      end else if (zw < -HALF_PI_Q30) begin
         z0_in   = zw + PI_Q30;
         neg0_in = 1'b1;
      end else begin
         z0_in   = zw;
         neg0_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]   <= GAIN_Q30;
         y_ff[0]   <= '0;
         z_ff[0]   <= z0_in;
         neg_ff[0] <= neg0_in;
      end
   end

   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      logic signed [XW-1:0] x_in;
      logic signed [XW-1:0] y_in;
      logic signed [ZW-1:0] z_in;

      always_comb begin
         if (!z_ff[i][ZW-1]) begin
            x_in = x_ff[i] - (y_ff[i] >>> i);
            y_in = y_ff[i] + (x_ff[i] >>> i);
            z_in = z_ff[i] - ATAN_Q30[i];
         end else begin
            x_in = x_ff[i] + (y_ff[i] >>> i);
            y_in = y_ff[i] - (x_ff[i] >>> i);
            z_in = z_ff[i] + ATAN_Q30[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i+1]   <= x_in;
            y_ff[i+1]   <= y_in;
            z_ff[i+1]   <= z_in;
            neg_ff[i+1] <= neg_ff[i];
         end
      end
   end

   always_comb begin
      if (neg_ff[STAGES]) begin
         trig_in.cos_q30 = -x_ff[STAGES];
         trig_in.sin_q30 = -y_ff[STAGES];
      end else begin
         trig_in.cos_q30 = x_ff[STAGES];
         trig_in.sin_q30 = y_ff[STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         trig_ff <= trig_in;
      end
   end

   assign trig = trig_ff;

endmodule
`default_nettype wire

>>> sv/lf2c_delay.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lf2c_delay
// Stallable delay line carrying valid bits and side data past the CORDIC.
// ----------------------------------------------------------------------------
module lf2c_delay #(
   parameter int DEPTH = 18
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 en,
   input  wire logic                 in_valid,
   input  lf2c_pkg::side_type        in_data,
   output logic                      out_valid,
   output lf2c_pkg::side_type        out_data
);
   import lf2c_pkg::*;

   logic     valid_ff [DEPTH];
   side_type data_ff  [DEPTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (en) begin
         valid_ff[0] <= in_valid;
         for (int i = 1; i < DEPTH; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff[0] <= in_data;
         for (int i = 1; i < DEPTH; i++) begin
            data_ff[i] <= data_ff[i-1];
         end
      end
   end

   assign out_valid = valid_ff[DEPTH-1];
   assign out_data  = data_ff[DEPTH-1];

endmodule
`default_nettype wire

>>> sv/lf2c_project.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lf2c_project
// Direction vector, basis transform, radius scaling, origin offset and
// saturation, as a six-stage pipeline ending in the output register.
// ----------------------------------------------------------------------------
module lf2c_project #(
   parameter int COORD_WIDTH = 24
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     en,
   input  wire logic                     in_valid,
   input  lf2c_pkg::trig_type            trig_az,
   input  lf2c_pkg::trig_type            trig_el,
   input  lf2c_pkg::side_type            side,
   output logic                          out_valid,
   output logic [COORD_WIDTH-1:0]        point_x,
   output logic [COORD_WIDTH-1:0]        point_y,
   output logic [COORD_WIDTH-1:0]        point_z
);
   import lf2c_pkg::*;

   localparam int PW    = 2 * XW;
   localparam int BPW   = COMP_W + XW;
   localparam int SUMW  = BPW + 2;
   localparam int SCW   = SUMW + DIST_W + 1;
   localparam int AW    = ((COORD_WIDTH > ORIGIN_W) ? COORD_WIDTH : ORIGIN_W) + 1;
   localparam logic signed [AW-1:0] SAT_HI = AW'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
   localparam logic signed [AW-1:0] SAT_LO = -SAT_HI - AW'(1);

   logic v_ff [6];

   logic signed [PW-1:0]  pdx_ff, pdy_ff;
   logic signed [XW-1:0]  cel1_ff;
   side_type              side1_ff, side2_ff;
   logic signed [XW-1:0]  d_ff [3];
   logic signed [PW-1:0]  rdx, rdy;
   logic signed [BPW-1:0] prod_ff [3][3];
   logic [DIST_W-1:0]     dist3_ff, dist4_ff;
   logic [ORIGIN_W-1:0]   org3_ff [3];
   logic [ORIGIN_W-1:0]   org4_ff [3];
   logic [ORIGIN_W-1:0]   org5_ff [3];
   logic signed [SUMW-1:0] sum_ff [3];
   logic signed [SCW-1:0]  scaled_ff [3];
   logic signed [SCW-1:0]  rnd [3];
   logic signed [SCW-1:0]  shr [3];
   logic signed [AW-1:0]   acc [3];
   logic [COORD_WIDTH-1:0] point_in [3];
   logic [COORD_WIDTH-1:0] point_ff [3];
   logic [ROW_W-1:0]       rows [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            v_ff[i] <= 1'b0;
         end
      end else if (en) begin
         v_ff[0] <= in_valid;
         for (int i = 1; i < 6; i++) begin
            v_ff[i] <= v_ff[i-1];
         end
      end
   end

   always_comb begin
      rdx = pdx_ff + PW'(64'd1 << 29);
      rdy = pdy_ff + PW'(64'd1 << 29);
      rows[0] = side2_ff.basis_row0;
      rows[1] = side2_ff.basis_row1;
      rows[2] = side2_ff.basis_row2;
      for (int c = 0; c < 3; c++) begin
         rnd[c] = scaled_ff[c] + SCW'(64'd1 << 43);
         shr[c] = rnd[c] >>> 44;
         acc[c] = AW'(shr[c]) + AW'($signed(org5_ff[c]));
         if (acc[c] > SAT_HI) begin
            point_in[c] = COORD_WIDTH'(SAT_HI);
         end else if (acc[c] < SAT_LO) begin
            point_in[c] = COORD_WIDTH'(SAT_LO);
         end else begin
            point_in[c] = COORD_WIDTH'(acc[c]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pdx_ff   <= $signed(trig_az.cos_q30) * $signed(trig_el.sin_q30);
         pdy_ff   <= $signed(trig_az.sin_q30) * $signed(trig_el.sin_q30);
         cel1_ff  <= $signed(trig_el.cos_q30);
         side1_ff <= side;

         d_ff[0]  <= XW'(rdx >>> 30);
         d_ff[1]  <= XW'(rdy >>> 30);
         d_ff[2]  <= cel1_ff;
         side2_ff <= side1_ff;

         for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
               prod_ff[c][r] <= $signed(rows[r][COMP_W*c +: COMP_W]) * d_ff[r];
            end
         end
         dist3_ff   <= side2_ff.distance;
         org3_ff[0] <= side2_ff.origin_x;
         org3_ff[1] <= side2_ff.origin_y;
         org3_ff[2] <= side2_ff.origin_z;

         for (int c = 0; c < 3; c++) begin
            sum_ff[c]  <= SUMW'(prod_ff[c][0]) + SUMW'(prod_ff[c][1])
                        + SUMW'(prod_ff[c][2]);
            org4_ff[c] <= org3_ff[c];
         end
         dist4_ff <= dist3_ff;

         for (int c = 0; c < 3; c++) begin
            scaled_ff[c] <= sum_ff[c] * $signed({1'b0, dist4_ff});
            org5_ff[c]   <= org4_ff[c];
            point_ff[c]  <= point_in[c];
         end
      end
   end

   assign out_valid = v_ff[5];
   assign point_x   = point_ff[0];
   assign point_y   = point_ff[1];
   assign point_z   = point_ff[2];

endmodule
`default_nettype wire

>>> sv/local_frame_spherical_to_cartesian.sv
`default_nettype none
// ----------------------------------------------------------------------------
// local_frame_spherical_to_cartesian
// Places a point given by azimuth, elevation and radius in a local frame
// described by a 3x3 basis and an origin, giving saturated Q20.4 coordinates.
//
//   Channel   Direction   Contents
//   req_      in          angles, radius, basis rows, origin
//   rsp_      out         cartesian point
//
// One transaction is accepted per cycle while the result channel is not stalled;
// a result passes through TRIG_STAGES + 8 register stages, set by the CORDIC
// stages plus the direction, transform and scaling stages. Reset clears only
// the valid bits. A stall on the result channel freezes the whole pipeline,
// and req_tready follows it in the same cycle.
// ----------------------------------------------------------------------------
module local_frame_spherical_to_cartesian #(
   parameter int TRIG_STAGES = 16,
   parameter int COORD_WIDTH = 24
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   // azimuth, elevation, distance, basis_row0, basis_row1, basis_row2,
   // origin_x, origin_y, origin_z
   input  wire logic [263:0]  req_tdata,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   // point_x, point_y, point_z, zero padding
   output logic [((3 * COORD_WIDTH + 7) / 8) * 8 - 1:0] rsp_tdata
);
   import lf2c_pkg::*;

   localparam int RSP_W = ((3 * COORD_WIDTH + 7) / 8) * 8;

   logic                   en;
   side_type               side_in;
   side_type               side_dly;
   logic                   valid_dly;
   trig_type               trig_az;
   trig_type               trig_el;
   logic [COORD_WIDTH-1:0] px, py, pz;

   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   assign side_in.distance   = req_tdata[47:32];
   assign side_in.basis_row0 = req_tdata[95:48];
   assign side_in.basis_row1 = req_tdata[143:96];
   assign side_in.basis_row2 = req_tdata[191:144];
   assign side_in.origin_x   = req_tdata[215:192];
   assign side_in.origin_y   = req_tdata[239:216];
   assign side_in.origin_z   = req_tdata[263:240];

   lf2c_cordic #(.STAGES(TRIG_STAGES)) u_cordic_az (
      .clock (clock),
      .en    (en),
      .angle ($signed(req_tdata[15:0])),
      .trig  (trig_az)
   );

   lf2c_cordic #(.STAGES(TRIG_STAGES)) u_cordic_el (
      .clock (clock),
      .en    (en),
      .angle ($signed(req_tdata[31:16])),
      .trig  (trig_el)
   );

   lf2c_delay #(.DEPTH(TRIG_STAGES + 2)) u_delay (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .in_data   (side_in),
      .out_valid (valid_dly),
      .out_data  (side_dly)
   );

   lf2c_project #(.COORD_WIDTH(COORD_WIDTH)) u_project (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (valid_dly),
      .trig_az   (trig_az),
      .trig_el   (trig_el),
      .side      (side_dly),
      .out_valid (rsp_tvalid),
      .point_x   (px),
      .point_y   (py),
      .point_z   (pz)
   );

   assign rsp_tdata = RSP_W'({pz, py, px});

`ifndef NO_ASSERTIONS
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid set straight after reset");

   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      (!reset && !req_tready) |=> ($stable(valid_dly) && $stable(trig_az)
                                   && $stable(trig_el)))
      else $error("pipeline moved during a stall");

   a_stall_holds_side: assert property (@(posedge clock) disable iff (reset)
      (!reset && !req_tready) |=> $stable(side_dly))
      else $error("side data moved during a stall");
`endif

endmodule
`default_nettype wire

>>> dv/lf2c_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lf2c_checker
// Watches both channels of the point placement block, works out each
// expected point from the accepted request and compares it with the response.
// ----------------------------------------------------------------------------
module lf2c_checker #(
   parameter int TRIG_STAGES = 16,
   parameter int COORD_WIDTH = 24
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   input  wire logic          req_tready,
   input  wire logic [263:0]  req_tdata,
   input  wire logic          rsp_tvalid,
   input  wire logic          rsp_tready,
   input  wire logic [((3 * COORD_WIDTH + 7) / 8) * 8 - 1:0] rsp_tdata,
   output int                 fail_count,
   output int                 pending_points,
   output int                 points_seen
);
   import lf2c_pkg::*;

   typedef logic [3*COORD_WIDTH-1:0] coord_set_type;

   coord_set_type point_queue[$];
   longint        atan_table[24];

   initial begin
      for (int i = 0; i < 24; i++) atan_table[i] = longint'(ATAN_Q30[i]);
   end

   function automatic longint shift_floor(longint v, int s);
      return v >>> s;
   endfunction

   function automatic void cordic_sincos(input longint angle, output longint c,
                                          output longint s);
      longint z, x, y, nx;
      bit     flip;
      z = angle * 131072;
      x = longint'(GAIN_Q30);
      y = 0;
      flip = 0;
      if (z > longint'(HALF_PI_Q30)) begin
         z -= longint'(PI_Q30);
         flip = 1;
      end else if (z < -longint'(HALF_PI_Q30)) begin
         z += longint'(PI_Q30);
         flip = 1;
      end
      for (int i = 0; i < TRIG_STAGES && i < 24; i++) begin
         if (z >= 0) begin
            nx = x - shift_floor(y, i);
            y  = y + shift_floor(x, i);
            z -= atan_table[i];
         end else begin
            nx = x + shift_floor(y, i);
            y  = y - shift_floor(x, i);
            z += atan_table[i];
         end
         x = nx;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   function automatic coord_set_type place_point(logic [263:0] d);
      longint ca, sa, ce, se, dir[3], sum, v, hi, lo, radius;
      coord_set_type p;
      cordic_sincos(longint'($signed(d[15:0])), ca, sa);
      cordic_sincos(longint'($signed(d[31:16])), ce, se);
      dir[0] = (ca * se + (64'sd1 <<< 29)) >>> 30;
      dir[1] = (sa * se + (64'sd1 <<< 29)) >>> 30;
      dir[2] = ce;
      radius = longint'(d[47:32]);
      hi = (64'sd1 <<< (COORD_WIDTH - 1)) - 1;
      lo = -hi - 1;
      for (int c = 0; c < 3; c++) begin
         sum = 0;
         for (int r = 0; r < 3; r++)
            sum += longint'($signed(d[48 + 48*r + 16*c +: 16])) * dir[r];
         v = ((sum * radius + (64'sd1 <<< 43)) >>> 44)
             + longint'($signed(d[192 + 24*c +: 24]));
         if (v > hi) v = hi;
         if (v < lo) v = lo;
         p[COORD_WIDTH*c +: COORD_WIDTH] = v[COORD_WIDTH-1:0];
      end
      return p;
   endfunction

   initial begin
      fail_count = 0;
      points_seen = 0;
      pending_points = 0;
   end

   always @(posedge clock) begin
      coord_set_type want, got;
      if (!reset) begin
         if (req_tvalid && req_tready) point_queue = {point_queue, place_point(req_tdata)};
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[3*COORD_WIDTH-1:0];
            points_seen++;
            if (point_queue.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected point %h", got);
            end else begin
               want = point_queue.pop_front();
               for (int c = 0; c < 3; c++)
                  if (want[COORD_WIDTH*c +: COORD_WIDTH] != got[COORD_WIDTH*c +: COORD_WIDTH])
                  begin
                     fail_count++;
                     if (fail_count <= 10)
                        $display("coordinate %0d: expected %0d got %0d", c,
                                 $signed(want[COORD_WIDTH*c +: COORD_WIDTH]),
                                 $signed(got[COORD_WIDTH*c +: COORD_WIDTH]));
                  end
            end
         end
      end
      pending_points = point_queue.size();
   end
endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random placement requests with bursty input and a
// stalling receiver; the checker predicts every point and counts mismatches.
// ----------------------------------------------------------------------------
module tb_top;
   localparam int RSP_W = ((3 * 24 + 7) / 8) * 8;

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [263:0]     req_tdata;
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;
   int               fail_count;
   int               pending_points;
   int               points_seen;
   int               cycle_count;
   bit               driving_done;

   local_frame_spherical_to_cartesian dut (.*);

   lf2c_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   // The receiver stalls in phases: some long free runs, some heavy stalling.
   initial begin
      int stall_pct;
      rsp_tready = 0;
      @(negedge clock);
      forever begin
         stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 80);
         repeat ($urandom_range(20, 200)) begin
            rsp_tready <= ($urandom_range(1, 100) > stall_pct);
            @(negedge clock);
         end
      end
   end

   function automatic logic [47:0] rand_row();
      logic [47:0] r;
      for (int i = 0; i < 3; i++) begin
         case ($urandom_range(0, 5))
            0: r[16*i +: 16] = 16'sh4000;
            1: r[16*i +: 16] = 16'shC000;
            2: r[16*i +: 16] = 16'h0000;
            3: r[16*i +: 16] = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            default: r[16*i +: 16] = 16'($urandom());
         endcase
      end
      return r;
   endfunction

   function automatic logic [23:0] rand_origin();
      case ($urandom_range(0, 3))
         0: return 24'(24'h7FFFFF - $urandom_range(0, 255));
         1: return 24'(24'h800000 + $urandom_range(0, 255));
         default: return 24'($urandom());
      endcase
   endfunction

   function automatic logic [15:0] rand_angle();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
         1: return 16'(($urandom_range(0, 1) ? 1 : -1) * $urandom_range(12860, 12880));
         default: return 16'($urandom());
      endcase
   endfunction

   task automatic send_request(logic [15:0] az, logic [15:0] el, logic [15:0] radius,
                               logic [143:0] basis, logic [71:0] origin);
      req_tvalid <= 1;
      req_tdata  <= {origin, basis, radius, el, az};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      logic [143:0] eye;
      int           sent;
      eye = {48'h4000_0000_0000, 48'h0000_4000_0000, 48'h0000_0000_4000};
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      cycle_count = 0;
      driving_done = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 0;

      send_request(16'h0000, 16'h0000, 16'h0000, eye, 72'h0);
      send_request(16'h7FFF, 16'h7FFF, 16'hFFFF, eye, 72'h0);
      send_request(16'h8000, 16'h8000, 16'hFFFF, eye, 72'h0);
      send_request(16'd12868, 16'd12868, 16'h0100, eye, 72'h0);
      send_request(-16'sd12868, 16'd12868, 16'h0100, eye, 72'h0);
      send_request(16'd25736, 16'd25736, 16'h0100, eye, 72'h0);
      send_request(-16'sd25736, -16'sd25736, 16'h0100, eye, 72'h0);
      send_request(16'd6434, 16'd6434, 16'hFFFF, {144{1'b1}}, 72'h0);
      send_request(16'h0000, 16'h0000, 16'hFFFF, {3{48'h7FFF_7FFF_7FFF}},
                   {24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF});
      send_request(16'd3000, 16'd3000, 16'hFFFF, {3{48'h8000_8000_8000}},
                   {24'h800000, 24'h800000, 24'h800000});
      send_request(16'd1000, 16'd20000, 16'h1234, {144{1'b1}}, {72{1'b1}});
      send_request(16'h5555, 16'hAAAA, 16'hAAAA,
                   {72{2'b10}}, {36{2'b01}});
      send_request(16'hAAAA, 16'h5555, 16'h5555,
                   {72{2'b01}}, {36{2'b10}});
      send_request(16'd500, 16'd8000, 16'h0001, eye, 72'h0);
      req_tvalid <= 0;
      @(negedge clock);

      sent = 0;
      while (sent < 1550) begin
         repeat ($urandom_range(1, 40)) begin
            send_request(rand_angle(), rand_angle(),
                         ($urandom_range(0, 4) == 0) ? 16'hFFFF : 16'($urandom()),
                         {rand_row(), rand_row(), rand_row()},
                         {rand_origin(), rand_origin(), rand_origin()});
            sent++;
         end
         if ($urandom_range(0, 2) != 0) begin
            req_tvalid <= 0;
            repeat ($urandom_range(1, 12)) @(negedge clock);
         end
      end
      req_tvalid <= 0;
      driving_done = 1;

      while (pending_points != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      $display("Placed %0d points from 14 directed and %0d random requests,", points_seen, sent);
      $display("with bursty input and a stalling receiver.");
      if (fail_count == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end
endmodule
